// File: hdl/i2c_register_master_defines.svh
// Assertion macros for the I2C register master checker.
// Depends on nothing; included by the checker file only.
`ifndef I2C_REGISTER_MASTER_DEFINES_SVH
`define I2C_REGISTER_MASTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define I2CM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define I2CM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/i2cm_pkg.sv
// Types, constants and sequencing tables of the I2C register master.
// Used by the front end, queue, sequencer and top level; depends on nothing.
`default_nettype none

package i2cm_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int STEP_WIDTH = 5;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd8;
   localparam logic [CSR_ADDR_WIDTH-3:0] REG_PHASE_TICKS = '0;

   // Positions past this one belong to the second read of a double read.
   localparam logic [STEP_WIDTH-1:0] HALF_POS = 5'd8;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_DREAD = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      SEG_END       = 4'd0,
      SEG_START     = 4'd1,
      SEG_RSTART    = 4'd2,
      SEG_SEND_DEV  = 4'd3,
      SEG_SEND_REG  = 4'd4,
      SEG_SEND_DATA = 4'd5,
      SEG_SEND_DEVR = 4'd6,
      SEG_RECV      = 4'd7,
      SEG_MNACK     = 4'd8,
      SEG_STOP      = 4'd9
   } seg_type;

   typedef struct packed {
      op_type     opcode;
      logic [7:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
   } cmd_type;

   typedef struct packed {
      logic    launch;
      cmd_type cmd;
      logic    sda_in;
   } tick_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic drive;
   } pins_type;

   typedef struct packed {
      logic        scl_out;
      logic        sda_out;
      logic        sda_drive;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_data;
      logic        nack_seen;
   } rsp_type;

   function automatic seg_type seg_at(op_type op, logic [STEP_WIDTH-1:0] pos);
      logic [STEP_WIDTH-1:0] p;
      seg_type s;
      p = pos;
      s = SEG_END;
      if (op == OP_DREAD && pos > HALF_POS) begin
         p = pos - HALF_POS;
      end
      unique case (p)
         5'd1: s = SEG_START;
         5'd2: s = SEG_SEND_DEV;
         5'd3: s = SEG_SEND_REG;
         5'd4: s = (op == OP_WRITE) ? SEG_SEND_DATA : SEG_RSTART;
         5'd5: s = (op == OP_WRITE) ? SEG_STOP : SEG_SEND_DEVR;
         5'd6: s = (op == OP_WRITE) ? SEG_END : SEG_RECV;
         5'd7: s = (op == OP_WRITE) ? SEG_END : SEG_MNACK;
         5'd8: s = (op == OP_WRITE) ? SEG_END : SEG_STOP;
         default: s = SEG_END;
      endcase
      return s;
   endfunction

   function automatic logic is_send(seg_type seg);
      return seg == SEG_SEND_DEV || seg == SEG_SEND_REG ||
             seg == SEG_SEND_DATA || seg == SEG_SEND_DEVR;
   endfunction

   function automatic logic [3:0] bits_of(seg_type seg);
      logic [3:0] n;
      n = 4'd1;
      if (is_send(seg)) begin
         n = 4'd9;
      end else if (seg == SEG_RECV) begin
         n = 4'd8;
      end
      return n;
   endfunction

   function automatic logic [2:0] phases_of(seg_type seg, logic [3:0] bit_idx);
      logic [2:0] n;
      unique case (seg)
         SEG_START:  n = 3'd2;
         SEG_RSTART: n = 3'd3;
         SEG_RECV:   n = 3'd2;
         SEG_MNACK:  n = 3'd3;
         SEG_STOP:   n = 3'd4;
         default:    n = (bit_idx >= 4'd8) ? 3'd4 : 3'd3;
      endcase
      return n;
   endfunction

   // Pin levels held through one bus phase.
   function automatic pins_type pins_for(seg_type seg, logic [3:0] bit_idx,
                                         logic [1:0] ph, logic keep, logic b);
      pins_type p;
      unique case (seg)
         SEG_START:  p = (ph == 2'd0) ? 3'b111 : 3'b101;
         SEG_RSTART: p = (ph == 2'd0) ? 3'b011 : ((ph == 2'd1) ? 3'b111 : 3'b101);
         SEG_RECV:   p = (ph == 2'd0) ? 3'b110 : 3'b010;
         SEG_MNACK:  p = (ph == 2'd1) ? 3'b111 : 3'b011;
         SEG_STOP: begin
            unique case (ph)
               2'd0:    p = {1'b0, keep, 1'b1};
               2'd1:    p = 3'b001;
               2'd2:    p = 3'b101;
               default: p = 3'b111;
            endcase
         end
         default: begin
            if (bit_idx >= 4'd8) begin
               p = (ph == 2'd0) ? 3'b011 : ((ph == 2'd2) ? 3'b110 : 3'b010);
            end else if (ph == 2'd0) begin
               p = {1'b0, keep, 1'b1};
            end else begin
               p = {ph == 2'd2, b, 1'b1};
            end
         end
      endcase
      return p;
   endfunction

   // Shift register contents on entry to a segment.
   function automatic logic [7:0] entry_shift(seg_type seg, logic [STEP_WIDTH-1:0] pos,
                                              cmd_type cmd, logic [7:0] cur);
      logic [7:0] s;
      unique case (seg)
         SEG_SEND_DEV:  s = cmd.device_address;
         SEG_SEND_DEVR: s = cmd.device_address + 8'd1;
         SEG_SEND_REG:  s = cmd.register_address + {7'd0, pos > HALF_POS};
         SEG_SEND_DATA: s = cmd.write_data;
         SEG_RECV:      s = 8'd0;
         default:       s = cur;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// File: hdl/i2cm_channels.sv
// Request and response channel interfaces of the I2C register master.
// Depends on nothing; payload fields follow the request and response items.
`default_nettype none

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [1:0] opcode;
   logic [7:0] device_address;
   logic [7:0] register_address;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, start_req, opcode, device_address, register_address,
                   write_data, sda_in, input ready);
   modport sink (input valid, start_req, opcode, device_address, register_address,
                 write_data, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic        valid;
   logic        ready;
   logic        scl_out;
   logic        sda_out;
   logic        sda_drive;
   logic        busy_res;
   logic        done_res;
   logic [15:0] read_data;
   logic        nack_seen;

   modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res,
                   read_data, nack_seen, input ready);
   modport sink (input valid, scl_out, sda_out, sda_drive, busy_res, done_res,
                 read_data, nack_seen, output ready);
endinterface

`default_nettype wire

// File: hdl/i2cm_front.sv
// Front end: accepts request ticks and classifies transaction launches.
// Depends on i2cm_pkg and i2cm_req_if.
`default_nettype none

module i2cm_front (
   i2cm_req_if.sink           req_ch,
   input  logic               push_ready,
   output logic               push_valid,
   output i2cm_pkg::tick_type push_data
);

   logic launch;

   // Only a start with a defined opcode launches a transaction.
   assign launch = req_ch.start_req && (req_ch.opcode <= 2'(i2cm_pkg::OP_DREAD));

   assign req_ch.ready = push_ready;
   assign push_valid = req_ch.valid;

   always_comb begin
      push_data.launch = launch;
      push_data.sda_in = req_ch.sda_in;
      push_data.cmd = '0;
      if (launch) begin
         push_data.cmd.opcode = i2cm_pkg::op_type'(req_ch.opcode);
         push_data.cmd.device_address = req_ch.device_address;
         push_data.cmd.register_address = req_ch.register_address;
         push_data.cmd.write_data = req_ch.write_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/i2cm_queue.sv
// Short request queue between the front end and the bus sequencer.
// Depends on i2cm_pkg for the queued request type.
`default_nettype none

module i2cm_queue #(
   parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  i2cm_pkg::tick_type push_data,
   output logic               push_ready,
   output logic               pop_valid,
   output i2cm_pkg::tick_type pop_data,
   input  logic               pop_ready
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   i2cm_pkg::tick_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push_fire, pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = entries_ff[rd_ff];
   assign push_fire = push_valid && push_ready;
   assign pop_fire = pop_valid && pop_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push_fire) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/i2cm_back.sv
// Bus sequencer: runs one tick of the I2C transaction per queued request
// and registers the response. Depends on i2cm_pkg and i2cm_rsp_if.
`default_nettype none

module i2cm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         phase_ticks,
   input  logic               pop_valid,
   input  i2cm_pkg::tick_type pop_data,
   output logic               pop_ready,
   i2cm_rsp_if.source         rsp_ch
);

   localparam int SW = i2cm_pkg::STEP_WIDTH;

   logic [SW-1:0] step_ff, step_in, eff_step, pos_next;
   logic [7:0] tick_ff, tick_in, eff_tick, tick_inc, limit;
   logic [3:0] bit_ff, bit_in, eff_bit, bit_next;
   logic [1:0] phase_ff, phase_in, eff_phase;
   logic [2:0] phase_next;
   logic [7:0] shift_ff, shift_in, shift_s;
   i2cm_pkg::cmd_type cmd_ff, eff_cmd;
   logic [15:0] result_ff, result_in, eff_result;
   logic nack_ff, nack_in, eff_nack;
   i2cm_pkg::pins_type pins_ff, pins_in;
   i2cm_pkg::seg_type seg_cur, seg_next;
   logic launch, done, pop_fire;
   logic rsp_valid_ff;
   i2cm_pkg::rsp_type rsp_ff, rsp_in;

   assign pop_ready = !rsp_valid_ff || rsp_ch.ready;
   assign pop_fire = pop_valid && pop_ready;

   // Apply a launch before the tick is run.
   always_comb begin
      launch = pop_data.launch && (step_ff == '0);
      eff_step = launch ? SW'(1) : step_ff;
      eff_cmd = launch ? pop_data.cmd : cmd_ff;
      eff_tick = launch ? '0 : tick_ff;
      eff_bit = launch ? '0 : bit_ff;
      eff_phase = launch ? '0 : phase_ff;
      eff_nack = launch ? 1'b0 : nack_ff;
      eff_result = launch ? '0 : result_ff;
      seg_cur = i2cm_pkg::seg_at(eff_cmd.opcode, eff_step);
   end

   // Pin levels: load at the first tick of each phase.
   always_comb begin
      pins_in = pins_ff;
      if (eff_step != '0 && eff_tick == '0) begin
         pins_in = i2cm_pkg::pins_for(seg_cur, eff_bit, eff_phase, pins_ff.sda,
                                      shift_ff[7]);
      end
   end

   // Sequencer next state.
   always_comb begin
      step_in = eff_step;
      tick_in = eff_tick;
      bit_in = eff_bit;
      phase_in = eff_phase;
      shift_in = shift_ff;
      shift_s = shift_ff;
      nack_in = eff_nack;
      result_in = eff_result;
      done = 1'b0;
      limit = (phase_ticks == '0) ? 8'd1 : phase_ticks;
      tick_inc = eff_tick + 8'd1;
      phase_next = {1'b0, eff_phase} + 3'd1;
      bit_next = eff_bit + 4'd1;
      pos_next = eff_step + SW'(1);
      seg_next = i2cm_pkg::seg_at(eff_cmd.opcode, pos_next);
      if (eff_step != '0) begin
         tick_in = tick_inc;
         if (tick_inc >= limit) begin
            tick_in = '0;
            if (i2cm_pkg::is_send(seg_cur) && eff_phase == 2'd2) begin
               if (eff_bit >= 4'd8) begin
                  nack_in = eff_nack | pop_data.sda_in;
               end else begin
                  shift_s = {shift_ff[6:0], 1'b0};
               end
            end else if (seg_cur == i2cm_pkg::SEG_RECV && eff_phase == 2'd0) begin
               shift_s = {shift_ff[6:0], pop_data.sda_in};
            end
            shift_in = shift_s;
            if (phase_next >= i2cm_pkg::phases_of(seg_cur, eff_bit)) begin
               phase_in = '0;
               bit_in = bit_next;
               if (bit_next >= i2cm_pkg::bits_of(seg_cur)) begin
                  bit_in = '0;
                  if (seg_cur == i2cm_pkg::SEG_RECV) begin
                     if (eff_step > i2cm_pkg::HALF_POS) begin
                        result_in = {eff_result[15:8], shift_s};
                     end else if (eff_cmd.opcode == i2cm_pkg::OP_DREAD) begin
                        result_in = {shift_s, 8'd0};
                     end else begin
                        result_in = {8'd0, shift_s};
                     end
                  end
                  if (seg_next == i2cm_pkg::SEG_END) begin
                     step_in = '0;
                     done = 1'b1;
                  end else begin
                     step_in = pos_next;
                     shift_in = i2cm_pkg::entry_shift(seg_next, pos_next, eff_cmd, shift_s);
                  end
               end
            end else begin
               phase_in = phase_next[1:0];
            end
         end
      end
   end

   always_comb begin
      rsp_in.scl_out = pins_in.scl;
      rsp_in.sda_out = pins_in.drive ? pins_in.sda : 1'b1;
      rsp_in.sda_drive = pins_in.drive;
      rsp_in.busy_res = (step_in != '0);
      rsp_in.done_res = done;
      rsp_in.read_data = result_in;
      rsp_in.nack_seen = nack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         tick_ff <= '0;
         bit_ff <= '0;
         phase_ff <= '0;
         shift_ff <= '0;
         cmd_ff <= '0;
         result_ff <= '0;
         nack_ff <= 1'b0;
         pins_ff <= 3'b111;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop_fire) begin
            step_ff <= step_in;
            tick_ff <= tick_in;
            bit_ff <= bit_in;
            phase_ff <= phase_in;
            shift_ff <= shift_in;
            cmd_ff <= eff_cmd;
            result_ff <= result_in;
            nack_ff <= nack_in;
            pins_ff <= pins_in;
         end
         if (pop_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.scl_out = rsp_ff.scl_out;
   assign rsp_ch.sda_out = rsp_ff.sda_out;
   assign rsp_ch.sda_drive = rsp_ff.sda_drive;
   assign rsp_ch.busy_res = rsp_ff.busy_res;
   assign rsp_ch.done_res = rsp_ff.done_res;
   assign rsp_ch.read_data = rsp_ff.read_data;
   assign rsp_ch.nack_seen = rsp_ff.nack_seen;

endmodule

`default_nettype wire

// File: hdl/i2c_register_master.sv
// Top level of the I2C register master: register port, front end, queue
// and bus sequencer. Depends on i2cm_pkg, the channel interfaces and submodules.
`default_nettype none

// Each request is one timing tick of an I2C master that runs register write,
// register read and double read transactions; every request yields exactly one
// response carrying the pin levels after that tick, busy/done status, the read
// result and the sticky slave NACK flag. One request is taken per clock cycle
// sustained while responses are taken: the sequencer updates all of its
// counters, the shift byte and the pins together per tick, so the queue drains
// at one entry a cycle unless responses stall. Each accepted request passes the
// queue, then the response register. A request with start_req set launches
// a transaction only while the sequencer is idle and the opcode is defined;
// otherwise it just advances time. Each bus phase lasts phase_ticks ticks
// (register 0, reset 8, zero acts as one); write it only while idle.
module i2c_register_master #(
   parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   i2cm_req_if.sink                            req_ch,
   i2cm_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [i2cm_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [i2cm_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [i2cm_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);

   logic [7:0] phase_ticks_ff, phase_ticks_in;
   logic [i2cm_pkg::CSR_ADDR_WIDTH-3:0] csr_index;
   logic csr_write;
   logic push_valid, push_ready, pop_valid, pop_ready;
   i2cm_pkg::tick_type push_data, pop_data;

   // Register port: no wait states; decode on the word index.
   assign pready = 1'b1;
   assign csr_index = paddr[i2cm_pkg::CSR_ADDR_WIDTH-1:2];
   assign csr_write = psel && penable && pwrite && pready &&
                      (csr_index == i2cm_pkg::REG_PHASE_TICKS);

   always_comb begin
      phase_ticks_in = phase_ticks_ff;
      if (csr_write) begin
         phase_ticks_in = pwdata[7:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == i2cm_pkg::REG_PHASE_TICKS) begin
         prdata = {{(i2cm_pkg::CSR_DATA_WIDTH - 8){1'b0}}, phase_ticks_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cm_pkg::PHASE_TICKS_RESET;
      end else begin
         phase_ticks_ff <= phase_ticks_in;
      end
   end

   // Classify each request tick; hold it in the queue when the back end stalls.
   i2cm_front u_front (
      .req_ch     (req_ch),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   i2cm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // Advance the bus sequencer one tick per popped request.
   i2cm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .phase_ticks (phase_ticks_ff),
      .pop_valid   (pop_valid),
      .pop_data    (pop_data),
      .pop_ready   (pop_ready),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

// File: hdl/i2cm_checker.sv
// Port-level checker for the I2C register master, bound to the top level.
// Depends on i2c_register_master_defines.svh for the assertion macros.
`default_nettype none
`include "i2c_register_master_defines.svh"

module i2cm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        sda_out,
   input logic        sda_drive,
   input logic        busy_res,
   input logic        done_res,
   input logic [15:0] read_data
);

   `I2CM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response after reset")
   `I2CM_ASSERT(a_done_idle, clock, reset, rsp_valid && done_res |-> !busy_res, "done while busy")
   `I2CM_ASSERT(a_released_high, clock, reset, rsp_valid && !sda_drive |-> sda_out, "released sda low")
   `I2CM_ASSERT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(done_res), "stalled response changed")

endmodule

bind i2c_register_master i2cm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .sda_out   (rsp_ch.sda_out),
   .sda_drive (rsp_ch.sda_drive),
   .busy_res  (rsp_ch.busy_res),
   .done_res  (rsp_ch.done_res),
   .read_data (rsp_ch.read_data)
);

`default_nettype wire

// File: sim/testbench.sv
// Testbench of the I2C register master: random and directed timing ticks,
// a tick-by-tick pin-level predictor in a scoreboard, APB writes of phase_ticks.
// Depends on i2cm_pkg, the channel interfaces and the i2c_register_master RTL.
`timescale 1ns / 100ps

module testbench;

   // Opcode that names no transaction; a request carrying it launches nothing.
   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam logic [i2cm_pkg::CSR_ADDR_WIDTH-1:0] PHASE_TICKS_ADDR =
      {i2cm_pkg::REG_PHASE_TICKS, 2'b00};
   // Margin beyond the queue and output register.
   localparam int DRAIN_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT = 500_000;

   typedef enum {SLAVE_ACKS, SLAVE_NOISY, SLAVE_ABSENT} slave_type;

   typedef struct packed {
      logic       launch;
      logic [1:0] opcode;
      logic [7:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } bus_tick_type;

   // Tracks the bus sequencer tick by tick and holds the pin levels, status and
   // read result expected for every accepted request, oldest first.
   class bus_level_scoreboard;
      logic [7:0]         phase_ticks;
      logic [4:0]         step;
      logic [7:0]         tick_cnt;
      logic [3:0]         bit_cnt;
      logic [2:0]         phase_idx;
      logic [7:0]         shifter;
      i2cm_pkg::cmd_type  cmd;
      logic [15:0]        read_word;
      logic               nack;
      i2cm_pkg::pins_type pins;
      i2cm_pkg::rsp_type  pending_levels[$];
      int                 mismatches;

      function new();
         phase_ticks = i2cm_pkg::PHASE_TICKS_RESET;
         step = '0;
         tick_cnt = '0;
         bit_cnt = '0;
         phase_idx = '0;
         shifter = '0;
         cmd = '0;
         read_word = '0;
         nack = 1'b0;
         pins = 3'b111;
         mismatches = 0;
      endfunction

      // Segment at a position of the latched transaction; a double read is
      // the single read program run twice.
      function i2cm_pkg::seg_type segment_at(int unsigned pos);
         i2cm_pkg::seg_type read_half[8];
         i2cm_pkg::seg_type write_prog[5];
         i2cm_pkg::seg_type s;
         read_half = '{i2cm_pkg::SEG_START, i2cm_pkg::SEG_SEND_DEV, i2cm_pkg::SEG_SEND_REG,
                       i2cm_pkg::SEG_RSTART, i2cm_pkg::SEG_SEND_DEVR, i2cm_pkg::SEG_RECV,
                       i2cm_pkg::SEG_MNACK, i2cm_pkg::SEG_STOP};
         write_prog = '{i2cm_pkg::SEG_START, i2cm_pkg::SEG_SEND_DEV, i2cm_pkg::SEG_SEND_REG,
                        i2cm_pkg::SEG_SEND_DATA, i2cm_pkg::SEG_STOP};
         s = i2cm_pkg::SEG_END;
         if (pos >= 1) begin
            case (cmd.opcode)
               i2cm_pkg::OP_WRITE: if (pos <= 5) s = write_prog[pos-1];
               i2cm_pkg::OP_READ:  if (pos <= 8) s = read_half[pos-1];
               i2cm_pkg::OP_DREAD: if (pos <= 16) s = read_half[(pos-1) % 8];
               default:            s = i2cm_pkg::SEG_END;
            endcase
         end
         return s;
      endfunction

      function bit sends_byte(i2cm_pkg::seg_type seg);
         return seg inside {i2cm_pkg::SEG_SEND_DEV, i2cm_pkg::SEG_SEND_REG,
                            i2cm_pkg::SEG_SEND_DATA, i2cm_pkg::SEG_SEND_DEVR};
      endfunction

      function int unsigned bit_total(i2cm_pkg::seg_type seg);
         if (sends_byte(seg)) return 9;
         if (seg == i2cm_pkg::SEG_RECV) return 8;
         return 1;
      endfunction

      function int unsigned phase_total(i2cm_pkg::seg_type seg);
         case (seg)
            i2cm_pkg::SEG_START, i2cm_pkg::SEG_RECV:   return 2;
            i2cm_pkg::SEG_RSTART, i2cm_pkg::SEG_MNACK: return 3;
            i2cm_pkg::SEG_STOP:                        return 4;
            default:                                   return (bit_cnt >= 8) ? 4 : 3;
         endcase
      endfunction

      // Levels {scl, sda, drive} held through the current phase.
      function i2cm_pkg::pins_type phase_pins(i2cm_pkg::seg_type seg);
         logic keep;
         i2cm_pkg::pins_type p;
         keep = pins.sda;
         case (seg)
            i2cm_pkg::SEG_START:  p = (phase_idx == 0) ? 3'b111 : 3'b101;
            i2cm_pkg::SEG_RSTART:
               p = (phase_idx == 0) ? 3'b011 : ((phase_idx == 1) ? 3'b111 : 3'b101);
            i2cm_pkg::SEG_RECV:   p = (phase_idx == 0) ? 3'b110 : 3'b010;
            i2cm_pkg::SEG_MNACK:  p = (phase_idx == 1) ? 3'b111 : 3'b011;
            i2cm_pkg::SEG_STOP: begin
               case (phase_idx)
                  0:       p = {1'b0, keep, 1'b1};
                  1:       p = 3'b001;
                  2:       p = 3'b101;
                  default: p = 3'b111;
               endcase
            end
            default: begin
               if (bit_cnt >= 8) begin
                  p = (phase_idx == 0) ? 3'b011 : ((phase_idx == 2) ? 3'b110 : 3'b010);
               end else if (phase_idx == 0) begin
                  p = {1'b0, keep, 1'b1};
               end else begin
                  p = {phase_idx == 2, shifter[7], 1'b1};
               end
            end
         endcase
         return p;
      endfunction

      function void load_shifter(i2cm_pkg::seg_type seg, int unsigned pos);
         case (seg)
            i2cm_pkg::SEG_SEND_DEV:  shifter = cmd.device_address;
            i2cm_pkg::SEG_SEND_DEVR: shifter = cmd.device_address + 8'd1;
            i2cm_pkg::SEG_SEND_REG:
               shifter = cmd.register_address + ((pos > 8) ? 8'd1 : 8'd0);
            i2cm_pkg::SEG_SEND_DATA: shifter = cmd.write_data;
            i2cm_pkg::SEG_RECV:      shifter = 8'd0;
            default:                 ;
         endcase
      endfunction

      function bit idle();
         return step == 0;
      endfunction

      // True while the next tick falls into a slave acknowledge slot.
      function bit in_ack_slot();
         return step != 0 && sends_byte(segment_at(step)) && bit_cnt >= 8;
      endfunction

      function int pending();
         return pending_levels.size();
      endfunction

      // Advance the sequencer by one accepted request and queue its response.
      function void note_request(bus_tick_type t);
         i2cm_pkg::rsp_type r;
         i2cm_pkg::seg_type seg;
         int unsigned       pos;
         int unsigned       limit;
         logic              done;
         done = 1'b0;
         if (step == 0 && t.launch && t.opcode != OP_UNDEFINED) begin
            cmd.opcode = i2cm_pkg::op_type'(t.opcode);
            cmd.device_address = t.device_address;
            cmd.register_address = t.register_address;
            cmd.write_data = t.write_data;
            nack = 1'b0;
            read_word = '0;
            step = 5'd1;
            tick_cnt = '0;
            bit_cnt = '0;
            phase_idx = '0;
            load_shifter(segment_at(1), 1);
         end
         if (step != 0) begin
            pos = step;
            seg = segment_at(pos);
            limit = (phase_ticks == 0) ? 1 : phase_ticks;
            if (tick_cnt == 0) pins = phase_pins(seg);
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= limit) begin
               tick_cnt = '0;
               if (sends_byte(seg) && phase_idx == 2) begin
                  if (bit_cnt >= 8) nack = nack | t.sda_in;
                  else shifter = shifter << 1;
               end else if (seg == i2cm_pkg::SEG_RECV && phase_idx == 0) begin
                  shifter = {shifter[6:0], t.sda_in};
               end
               phase_idx = phase_idx + 3'd1;
               if (phase_idx >= phase_total(seg)) begin
                  phase_idx = '0;
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= bit_total(seg)) begin
                     bit_cnt = '0;
                     if (seg == i2cm_pkg::SEG_RECV) begin
                        if (pos > 8) read_word[7:0] = shifter;
                        else if (cmd.opcode == i2cm_pkg::OP_DREAD) read_word = {shifter, 8'h00};
                        else read_word = {8'h00, shifter};
                     end
                     pos++;
                     seg = segment_at(pos);
                     if (seg == i2cm_pkg::SEG_END) begin
                        step = '0;
                        done = 1'b1;
                     end else begin
                        step = 5'(pos);
                        load_shifter(seg, pos);
                     end
                  end
               end
            end
         end
         r.scl_out = pins.scl;
         r.sda_out = pins.drive ? pins.sda : 1'b1;
         r.sda_drive = pins.drive;
         r.busy_res = step != 0;
         r.done_res = done;
         r.read_data = read_word;
         r.nack_seen = nack;
         pending_levels.push_back(r);
      endfunction

      function string show(i2cm_pkg::rsp_type r);
         return $sformatf("scl %0b sda %0b drive %0b busy %0b done %0b data %h nack %0b",
                          r.scl_out, r.sda_out, r.sda_drive, r.busy_res, r.done_res,
                          r.read_data, r.nack_seen);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      function void check_response(i2cm_pkg::rsp_type got);
         i2cm_pkg::rsp_type want;
         string             diff;
         if (pending_levels.size() == 0) begin
            report({"response without a pending request: ", show(got)});
            return;
         end
         want = pending_levels.pop_front();
         diff = "";
         if (got.scl_out !== want.scl_out) diff = {diff, " scl_out"};
         if (got.sda_out !== want.sda_out) diff = {diff, " sda_out"};
         if (got.sda_drive !== want.sda_drive) diff = {diff, " sda_drive"};
         if (got.busy_res !== want.busy_res) diff = {diff, " busy_res"};
         if (got.done_res !== want.done_res) diff = {diff, " done_res"};
         if (got.read_data !== want.read_data) diff = {diff, " read_data"};
         if (got.nack_seen !== want.nack_seen) diff = {diff, " nack_seen"};
         if (diff != "") begin
            report({"mismatch in", diff, "\n   expected ", show(want),
                    "\n   actual   ", show(got)});
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [i2cm_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [i2cm_pkg::CSR_DATA_WIDTH-1:0] pwdata;
   logic [i2cm_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                                pready;

   i2cm_req_if req();
   i2cm_rsp_if rsp();

   bus_level_scoreboard board;
   int unsigned         cycles = 0;
   int unsigned         ticks_sent = 0;
   bit                  sending = 1'b0;
   bit                  steady = 1'b0;
   slave_type           slave = SLAVE_ACKS;

   i2c_register_master i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req),
      .rsp_ch  (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hang guard: a correct run ends far below this.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Check every response taken by the sink side.
   always @(posedge clock) begin : watch_responses
      i2cm_pkg::rsp_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.scl_out = rsp.scl_out;
         got.sda_out = rsp.sda_out;
         got.sda_drive = rsp.sda_drive;
         got.busy_res = rsp.busy_res;
         got.done_res = rsp.done_res;
         got.read_data = rsp.read_data;
         got.nack_seen = rsp.nack_seen;
         board.check_response(got);
      end
   end

   // Response backpressure: bursts of ready, mostly short stalls, a few long
   // ones, and now and then a long stretch with no stall at all.
   initial begin : response_sink
      int unsigned run;
      int unsigned hold;
      int unsigned r;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp.ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
         repeat (run) @(posedge clock);
         r = $urandom_range(0, 99);
         if (r < 50) hold = 0;
         else if (r < 90) hold = $urandom_range(1, 3);
         else if (r < 98) hold = $urandom_range(4, 12);
         else hold = $urandom_range(20, 40);
         if (hold > 0) begin
            rsp.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   function automatic int unsigned sender_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // Drive one request, hold it until taken, then note it and maybe idle.
   task automatic push_tick(input bus_tick_type t);
      int unsigned gap;
      req.valid <= 1'b1;
      req.start_req <= t.launch;
      req.opcode <= t.opcode;
      req.device_address <= t.device_address;
      req.register_address <= t.register_address;
      req.write_data <= t.write_data;
      req.sda_in <= t.sda_in;
      sending = 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_request(t);
      ticks_sent++;
      gap = sender_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         sending = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One tick; the slave side decides what SDA reads back.
   task automatic tick(input logic launch, input logic [1:0] op, input logic [7:0] dev,
                       input logic [7:0] reg_index, input logic [7:0] data);
      bus_tick_type t;
      t.launch = launch;
      t.opcode = op;
      t.device_address = dev;
      t.register_address = reg_index;
      t.write_data = data;
      case (slave)
         SLAVE_ACKS:   t.sda_in = board.in_ack_slot() ? 1'b0 : 1'($urandom_range(0, 1));
         SLAVE_NOISY:  t.sda_in = 1'($urandom_range(0, 1));
         default:      t.sda_in = 1'b1;
      endcase
      push_tick(t);
   endtask

   // Launch a transaction and tick until the sequencer is idle again; requests
   // raised while busy carry random commands that must be ignored.
   task automatic run_transaction(input logic [1:0] op, input logic [7:0] dev,
                                  input logic [7:0] reg_index, input logic [7:0] data,
                                  input slave_type mode);
      slave = mode;
      steady = ($urandom_range(0, 4) == 0);
      tick(1'b1, op, dev, reg_index, data);
      while (!board.idle()) begin
         tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic csr_write(input logic [i2cm_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            input logic [i2cm_pkg::CSR_DATA_WIDTH-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Drop valid and wait out every pending response before touching the
   // register or ending the run.
   task automatic drain();
      if (sending) begin
         req.valid <= 1'b0;
         sending = 1'b0;
      end
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_phase_ticks(input logic [7:0] value);
      drain();
      csr_write(PHASE_TICKS_ADDR, {{(i2cm_pkg::CSR_DATA_WIDTH-8){1'b0}}, value});
      board.phase_ticks = value;
   endtask

   // Mostly complete transactions with random content; the rest is idle noise
   // and undefined-opcode requests. Always ends with the sequencer idle.
   task automatic random_phase(input logic [7:0] value, input int unsigned budget);
      int unsigned target;
      int unsigned r;
      logic [1:0]  op;
      slave_type   mode;
      set_phase_ticks(value);
      target = ticks_sent + budget;
      while (ticks_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            steady = 1'b0;
            tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            op = ($urandom_range(0, 19) == 0) ? OP_UNDEFINED : 2'($urandom_range(0, 2));
            r = $urandom_range(0, 99);
            mode = (r < 70) ? SLAVE_ACKS : ((r < 90) ? SLAVE_NOISY : SLAVE_ABSENT);
            run_transaction(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), mode);
         end
      end
   endtask

   initial begin
      board = new();
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.start_req <= 1'b0;
      req.opcode <= i2cm_pkg::OP_WRITE;
      req.device_address <= '0;
      req.register_address <= '0;
      req.write_data <= '0;
      req.sda_in <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero phase length runs like one; field extremes first.
      set_phase_ticks(8'd0);
      run_transaction(i2cm_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, SLAVE_ABSENT);
      // device+1 wraps to zero on the read address
      run_transaction(i2cm_pkg::OP_READ, 8'hFF, 8'h00, 8'h00, SLAVE_ACKS);
      // register+1 wraps on the second half; all-ones read back
      run_transaction(i2cm_pkg::OP_DREAD, 8'h7F, 8'hFF, 8'h00, SLAVE_ABSENT);
      run_transaction(OP_UNDEFINED, 8'hA5, 8'h5A, 8'hC3, SLAVE_ACKS);

      random_phase(8'd1, 300);
      random_phase(8'($urandom_range(2, 3)), 1);

      drain();
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
